// ===== hw/rtl/axsd_pkg.sv =====
// Shared types, AES tables and GF(2^128) helpers for the XTS sector decryptor.
package axsd_pkg;

    typedef logic [127:0] t_blk;
    typedef logic [7:0]   t_byte;
    typedef logic [31:0]  t_word;

    // Widest block index the sector size range can ask for (4096 / 16 blocks).
    localparam int IDX_MAX_W = 8;
    localparam int CFG_IDX_W = 3;

    localparam logic [63:0] SECTOR_MAX = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam logic [7:0]  SPB_DEFAULT = 8'd8;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_DKEY_LO = 3'd0,
        REG_DKEY_HI = 3'd1,
        REG_TKEY_LO = 3'd2,
        REG_TKEY_HI = 3'd3,
        REG_SPB     = 3'd4
    } t_reg_idx;

    // Item moving through the tweak encryption cells.
    typedef struct packed {
        t_blk                 st;     // tweak cipher state
        t_blk                 tk;     // tweak round key
        t_blk                 dk;     // data round key (forward schedule)
        t_blk                 ct;     // ciphertext block
        logic [IDX_MAX_W-1:0] idx;    // block index inside the sector
        logic                 failed;
        logic                 zero_tw;
    } t_enc_bus;

    // Item moving through the tweak scaling cells.
    typedef struct packed {
        t_blk                 tw;
        t_blk                 dk;
        t_blk                 ct;
        logic [IDX_MAX_W-1:0] idx;
        logic                 failed;
    } t_scl_bus;

    // Item moving through the decryption cells.
    typedef struct packed {
        t_blk st;
        t_blk tw;
        t_blk dk;
        logic failed;
    } t_dec_bus;

    localparam t_byte RCON [10] = '{
        8'h01, 8'h02, 8'h04, 8'h08, 8'h10, 8'h20, 8'h40, 8'h80, 8'h1b, 8'h36
    };

    localparam t_byte SBOX [256] = '{
        8'h63, 8'h7c, 8'h77, 8'h7b, 8'hf2, 8'h6b, 8'h6f, 8'hc5,
        8'h30, 8'h01, 8'h67, 8'h2b, 8'hfe, 8'hd7, 8'hab, 8'h76,
        8'hca, 8'h82, 8'hc9, 8'h7d, 8'hfa, 8'h59, 8'h47, 8'hf0,
        8'had, 8'hd4, 8'ha2, 8'haf, 8'h9c, 8'ha4, 8'h72, 8'hc0,
        8'hb7, 8'hfd, 8'h93, 8'h26, 8'h36, 8'h3f, 8'hf7, 8'hcc,
        8'h34, 8'ha5, 8'he5, 8'hf1, 8'h71, 8'hd8, 8'h31, 8'h15,
        8'h04, 8'hc7, 8'h23, 8'hc3, 8'h18, 8'h96, 8'h05, 8'h9a,
        8'h07, 8'h12, 8'h80, 8'he2, 8'heb, 8'h27, 8'hb2, 8'h75,
        8'h09, 8'h83, 8'h2c, 8'h1a, 8'h1b, 8'h6e, 8'h5a, 8'ha0,
        8'h52, 8'h3b, 8'hd6, 8'hb3, 8'h29, 8'he3, 8'h2f, 8'h84,
        8'h53, 8'hd1, 8'h00, 8'hed, 8'h20, 8'hfc, 8'hb1, 8'h5b,
        8'h6a, 8'hcb, 8'hbe, 8'h39, 8'h4a, 8'h4c, 8'h58, 8'hcf,
        8'hd0, 8'hef, 8'haa, 8'hfb, 8'h43, 8'h4d, 8'h33, 8'h85,
        8'h45, 8'hf9, 8'h02, 8'h7f, 8'h50, 8'h3c, 8'h9f, 8'ha8,
        8'h51, 8'ha3, 8'h40, 8'h8f, 8'h92, 8'h9d, 8'h38, 8'hf5,
        8'hbc, 8'hb6, 8'hda, 8'h21, 8'h10, 8'hff, 8'hf3, 8'hd2,
        8'hcd, 8'h0c, 8'h13, 8'hec, 8'h5f, 8'h97, 8'h44, 8'h17,
        8'hc4, 8'ha7, 8'h7e, 8'h3d, 8'h64, 8'h5d, 8'h19, 8'h73,
        8'h60, 8'h81, 8'h4f, 8'hdc, 8'h22, 8'h2a, 8'h90, 8'h88,
        8'h46, 8'hee, 8'hb8, 8'h14, 8'hde, 8'h5e, 8'h0b, 8'hdb,
        8'he0, 8'h32, 8'h3a, 8'h0a, 8'h49, 8'h06, 8'h24, 8'h5c,
        8'hc2, 8'hd3, 8'hac, 8'h62, 8'h91, 8'h95, 8'he4, 8'h79,
        8'he7, 8'hc8, 8'h37, 8'h6d, 8'h8d, 8'hd5, 8'h4e, 8'ha9,
        8'h6c, 8'h56, 8'hf4, 8'hea, 8'h65, 8'h7a, 8'hae, 8'h08,
        8'hba, 8'h78, 8'h25, 8'h2e, 8'h1c, 8'ha6, 8'hb4, 8'hc6,
        8'he8, 8'hdd, 8'h74, 8'h1f, 8'h4b, 8'hbd, 8'h8b, 8'h8a,
        8'h70, 8'h3e, 8'hb5, 8'h66, 8'h48, 8'h03, 8'hf6, 8'h0e,
        8'h61, 8'h35, 8'h57, 8'hb9, 8'h86, 8'hc1, 8'h1d, 8'h9e,
        8'he1, 8'hf8, 8'h98, 8'h11, 8'h69, 8'hd9, 8'h8e, 8'h94,
        8'h9b, 8'h1e, 8'h87, 8'he9, 8'hce, 8'h55, 8'h28, 8'hdf,
        8'h8c, 8'ha1, 8'h89, 8'h0d, 8'hbf, 8'he6, 8'h42, 8'h68,
        8'h41, 8'h99, 8'h2d, 8'h0f, 8'hb0, 8'h54, 8'hbb, 8'h16
    };

    localparam t_byte INV_SBOX [256] = '{
        8'h52, 8'h09, 8'h6a, 8'hd5, 8'h30, 8'h36, 8'ha5, 8'h38,
        8'hbf, 8'h40, 8'ha3, 8'h9e, 8'h81, 8'hf3, 8'hd7, 8'hfb,
        8'h7c, 8'he3, 8'h39, 8'h82, 8'h9b, 8'h2f, 8'hff, 8'h87,
        8'h34, 8'h8e, 8'h43, 8'h44, 8'hc4, 8'hde, 8'he9, 8'hcb,
        8'h54, 8'h7b, 8'h94, 8'h32, 8'ha6, 8'hc2, 8'h23, 8'h3d,
        8'hee, 8'h4c, 8'h95, 8'h0b, 8'h42, 8'hfa, 8'hc3, 8'h4e,
        8'h08, 8'h2e, 8'ha1, 8'h66, 8'h28, 8'hd9, 8'h24, 8'hb2,
        8'h76, 8'h5b, 8'ha2, 8'h49, 8'h6d, 8'h8b, 8'hd1, 8'h25,
        8'h72, 8'hf8, 8'hf6, 8'h64, 8'h86, 8'h68, 8'h98, 8'h16,
        8'hd4, 8'ha4, 8'h5c, 8'hcc, 8'h5d, 8'h65, 8'hb6, 8'h92,
        8'h6c, 8'h70, 8'h48, 8'h50, 8'hfd, 8'hed, 8'hb9, 8'hda,
        8'h5e, 8'h15, 8'h46, 8'h57, 8'ha7, 8'h8d, 8'h9d, 8'h84,
        8'h90, 8'hd8, 8'hab, 8'h00, 8'h8c, 8'hbc, 8'hd3, 8'h0a,
        8'hf7, 8'he4, 8'h58, 8'h05, 8'hb8, 8'hb3, 8'h45, 8'h06,
        8'hd0, 8'h2c, 8'h1e, 8'h8f, 8'hca, 8'h3f, 8'h0f, 8'h02,
        8'hc1, 8'haf, 8'hbd, 8'h03, 8'h01, 8'h13, 8'h8a, 8'h6b,
        8'h3a, 8'h91, 8'h11, 8'h41, 8'h4f, 8'h67, 8'hdc, 8'hea,
        8'h97, 8'hf2, 8'hcf, 8'hce, 8'hf0, 8'hb4, 8'he6, 8'h73,
        8'h96, 8'hac, 8'h74, 8'h22, 8'he7, 8'had, 8'h35, 8'h85,
        8'he2, 8'hf9, 8'h37, 8'he8, 8'h1c, 8'h75, 8'hdf, 8'h6e,
        8'h47, 8'hf1, 8'h1a, 8'h71, 8'h1d, 8'h29, 8'hc5, 8'h89,
        8'h6f, 8'hb7, 8'h62, 8'h0e, 8'haa, 8'h18, 8'hbe, 8'h1b,
        8'hfc, 8'h56, 8'h3e, 8'h4b, 8'hc6, 8'hd2, 8'h79, 8'h20,
        8'h9a, 8'hdb, 8'hc0, 8'hfe, 8'h78, 8'hcd, 8'h5a, 8'hf4,
        8'h1f, 8'hdd, 8'ha8, 8'h33, 8'h88, 8'h07, 8'hc7, 8'h31,
        8'hb1, 8'h12, 8'h10, 8'h59, 8'h27, 8'h80, 8'hec, 8'h5f,
        8'h60, 8'h51, 8'h7f, 8'ha9, 8'h19, 8'hb5, 8'h4a, 8'h0d,
        8'h2d, 8'he5, 8'h7a, 8'h9f, 8'h93, 8'hc9, 8'h9c, 8'hef,
        8'ha0, 8'he0, 8'h3b, 8'h4d, 8'hae, 8'h2a, 8'hf5, 8'hb0,
        8'hc8, 8'heb, 8'hbb, 8'h3c, 8'h83, 8'h53, 8'h99, 8'h61,
        8'h17, 8'h2b, 8'h04, 8'h7e, 8'hba, 8'h77, 8'hd6, 8'h26,
        8'he1, 8'h69, 8'h14, 8'h63, 8'h55, 8'h21, 8'h0c, 8'h7d
    };

    function automatic t_byte xt(input t_byte a);
        return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
    endfunction

    function automatic t_blk sub_bytes(input t_blk s);
        t_blk o;
        for (int i = 0; i < 16; i++) begin
            o[8*i +: 8] = SBOX[s[8*i +: 8]];
        end
        return o;
    endfunction

    function automatic t_blk inv_sub_bytes(input t_blk s);
        t_blk o;
        for (int i = 0; i < 16; i++) begin
            o[8*i +: 8] = INV_SBOX[s[8*i +: 8]];
        end
        return o;
    endfunction

    // Byte r of column c lives at index r + 4c.
    function automatic t_blk shift_rows(input t_blk s);
        t_blk o;
        for (int r = 0; r < 4; r++) begin
            for (int c = 0; c < 4; c++) begin
                o[8*(r + 4*c) +: 8] = s[8*(r + 4*((c + r) % 4)) +: 8];
            end
        end
        return o;
    endfunction

    function automatic t_blk inv_shift_rows(input t_blk s);
        t_blk o;
        for (int r = 0; r < 4; r++) begin
            for (int c = 0; c < 4; c++) begin
                o[8*(r + 4*((c + r) % 4)) +: 8] = s[8*(r + 4*c) +: 8];
            end
        end
        return o;
    endfunction

    function automatic t_blk mix_columns(input t_blk s);
        t_blk  o;
        t_byte a0, a1, a2, a3;
        for (int c = 0; c < 4; c++) begin
            a0 = s[32*c +: 8];
            a1 = s[32*c + 8 +: 8];
            a2 = s[32*c + 16 +: 8];
            a3 = s[32*c + 24 +: 8];
            o[32*c +: 8]      = xt(a0) ^ xt(a1) ^ a1 ^ a2 ^ a3;
            o[32*c + 8 +: 8]  = a0 ^ xt(a1) ^ xt(a2) ^ a2 ^ a3;
            o[32*c + 16 +: 8] = a0 ^ a1 ^ xt(a2) ^ xt(a3) ^ a3;
            o[32*c + 24 +: 8] = xt(a0) ^ a0 ^ a1 ^ a2 ^ xt(a3);
        end
        return o;
    endfunction

    function automatic t_blk inv_mix_columns(input t_blk s);
        t_blk  o;
        t_byte a   [4];
        t_byte m9  [4];
        t_byte m11 [4];
        t_byte m13 [4];
        t_byte m14 [4];
        t_byte x2, x4, x8;
        for (int c = 0; c < 4; c++) begin
            for (int b = 0; b < 4; b++) begin
                a[b]   = s[32*c + 8*b +: 8];
                x2     = xt(a[b]);
                x4     = xt(x2);
                x8     = xt(x4);
                m9[b]  = x8 ^ a[b];
                m11[b] = x8 ^ x2 ^ a[b];
                m13[b] = x8 ^ x4 ^ a[b];
                m14[b] = x8 ^ x4 ^ x2;
            end
            o[32*c +: 8]      = m14[0] ^ m11[1] ^ m13[2] ^ m9[3];
            o[32*c + 8 +: 8]  = m9[0] ^ m14[1] ^ m11[2] ^ m13[3];
            o[32*c + 16 +: 8] = m13[0] ^ m9[1] ^ m14[2] ^ m11[3];
            o[32*c + 24 +: 8] = m11[0] ^ m13[1] ^ m9[2] ^ m14[3];
        end
        return o;
    endfunction

    // Rotate, substitute and add the round constant to one schedule word.
    function automatic t_word key_g(input t_word w, input t_byte rc);
        t_word r;
        t_word o;
        r = {w[7:0], w[31:8]};
        for (int b = 0; b < 4; b++) begin
            o[8*b +: 8] = SBOX[r[8*b +: 8]];
        end
        return o ^ {24'h0, rc};
    endfunction

    function automatic t_blk key_next(input t_blk k, input t_byte rc);
        t_word w0, w1, w2, w3;
        w0 = k[31:0] ^ key_g(k[127:96], rc);
        w1 = k[63:32] ^ w0;
        w2 = k[95:64] ^ w1;
        w3 = k[127:96] ^ w2;
        return {w3, w2, w1, w0};
    endfunction

    function automatic t_blk key_prev(input t_blk k, input t_byte rc);
        t_word w0, w1, w2, w3;
        w3 = k[127:96] ^ k[95:64];
        w2 = k[95:64] ^ k[63:32];
        w1 = k[63:32] ^ k[31:0];
        w0 = k[31:0] ^ key_g(w3, rc);
        return {w3, w2, w1, w0};
    endfunction

    // Multiply by x^sh in GF(2^128) with feedback 0x87, for sh up to 128.
    function automatic t_blk mulx_pow(input t_blk t, input int sh);
        logic [255:0] w;
        logic [255:0] o;
        logic [255:0] r1;
        logic [127:0] top;
        logic [127:0] r2;
        w   = {128'h0, t} << sh;
        o   = {128'h0, w[255:128]};
        r1  = o ^ (o << 1) ^ (o << 2) ^ (o << 7);
        top = r1[255:128];
        r2  = top ^ (top << 1) ^ (top << 2) ^ (top << 7);
        return w[127:0] ^ r1[127:0] ^ r2;
    endfunction

endpackage

// ===== hw/rtl/axsd_enc_cell.sv =====
// One AES-128 encryption round cell of the tweak chain, with both key schedules.
module axsd_enc_cell #(
    parameter int ROUND = 1
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_adv,
    input  logic              i_valid,
    input  axsd_pkg::t_enc_bus i_data,
    output logic              o_valid,
    output axsd_pkg::t_enc_bus o_data
);

    logic               r_valid;
    axsd_pkg::t_enc_bus r_data;
    axsd_pkg::t_enc_bus n_data;
    axsd_pkg::t_blk     w_sr;

    always_comb begin
        n_data    = i_data;
        n_data.tk = axsd_pkg::key_next(i_data.tk, axsd_pkg::RCON[ROUND-1]);
        n_data.dk = axsd_pkg::key_next(i_data.dk, axsd_pkg::RCON[ROUND-1]);
        w_sr      = axsd_pkg::shift_rows(axsd_pkg::sub_bytes(i_data.st ^ i_data.tk));
        if (ROUND == 10) begin
            // final round: no column mix, add the last key, drop the tweak if unloaded
            n_data.st = i_data.zero_tw ? '0 : (w_sr ^ n_data.tk);
        end else begin
            n_data.st = axsd_pkg::mix_columns(w_sr);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_adv) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_data <= n_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

// ===== hw/rtl/axsd_scale_cell.sv =====
// One tweak scaling cell: multiply by x^(2^BIT) when that bit of the block index is set.
module axsd_scale_cell #(
    parameter int BIT = 0
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_adv,
    input  logic              i_valid,
    input  axsd_pkg::t_scl_bus i_data,
    output logic              o_valid,
    output axsd_pkg::t_scl_bus o_data
);

    logic               r_valid;
    axsd_pkg::t_scl_bus r_data;
    axsd_pkg::t_scl_bus n_data;

    always_comb begin
        n_data = i_data;
        if (i_data.idx[BIT]) begin
            n_data.tw = axsd_pkg::mulx_pow(i_data.tw, 1 << BIT);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_adv) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_data <= n_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

// ===== hw/rtl/axsd_dec_cell.sv =====
// One AES-128 decryption round cell with the reverse data key schedule.
module axsd_dec_cell #(
    parameter int ROUND = 9
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_adv,
    input  logic              i_valid,
    input  axsd_pkg::t_dec_bus i_data,
    output logic              o_valid,
    output axsd_pkg::t_dec_bus o_data
);

    logic               r_valid;
    axsd_pkg::t_dec_bus r_data;
    axsd_pkg::t_dec_bus n_data;
    axsd_pkg::t_blk     w_ak;

    always_comb begin
        n_data    = i_data;
        n_data.dk = axsd_pkg::key_prev(i_data.dk, axsd_pkg::RCON[ROUND]);
        w_ak      = axsd_pkg::inv_sub_bytes(axsd_pkg::inv_shift_rows(i_data.st)) ^ n_data.dk;
        if (ROUND == 0) begin
            // last round: remove the tweak, blank the block of a failed request
            n_data.st = i_data.failed ? '0 : (w_ak ^ i_data.tw);
        end else begin
            n_data.st = axsd_pkg::inv_mix_columns(w_ak);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_adv) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_data <= n_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

// ===== hw/rtl/aes_xts_sector_decrypt.sv =====
// Top level of the AES-128-XTS sector decryptor: request tracking and the cell chain.
//
// Usage:
//   s_axis carries one 16-byte ciphertext block per transfer. tdata holds
//   cipher_low, cipher_high, base_number and sector_delta (signed); tuser holds
//   start_req (bit 0) and number_is_block (bit 1). A transfer with start_req
//   set opens a request and sets its starting sector.
//   m_axis returns one plaintext block per input transfer, in order; tuser
//   is the error flag of a request whose start sector came out negative,
//   in which case tdata is zero.
//   The cfg channel writes the keys and sectors_per_block; it is always
//   ready. Write it only while no block is in flight.
// Throughput: one block per cycle while m_axis does not stall. Each block
// re-encrypts its sector's tweak under the tweak key latched when that
// sector's tweak was loaded. Stages: 1 entry stage + 10 tweak encryption cells +
// log2(SECTOR_BYTES/16) tweak scaling cells (at least one) + 10 decryption cells.
// The last decryption cell is the output register. While it holds a result
// and m_axis stalls, the whole chain holds and s_axis_tready drops.
// Reset clears the request state (sector 0, zero tweak) and all valid bits;
// keys reset to zero and sectors_per_block to 8.
module aes_xts_sector_decrypt #(
    parameter int SECTOR_BYTES = 512
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    // cfg write channel
    input  logic         i_cfg_valid,
    output logic         o_cfg_ready,
    input  logic [2:0]   i_cfg_index,
    input  logic [63:0]  i_cfg_data,
    // input stream
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [255:0] s_axis_tdata,  // cipher_low, cipher_high, base_number, sector_delta
    input  logic [1:0]   s_axis_tuser,  // start_req, number_is_block
    // output stream
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [127:0] m_axis_tdata,  // plain_low, plain_high
    output logic         m_axis_tuser   // error
);

    localparam int PER_SECTOR = (SECTOR_BYTES / 16 < 1) ? 1 : SECTOR_BYTES / 16;
    localparam int IDX_W      = (PER_SECTOR > 1) ? $clog2(PER_SECTOR) : 1;
    localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(PER_SECTOR - 1);

    // Configuration registers
    logic [63:0] r_dkey_lo, r_dkey_hi, r_tkey_lo, r_tkey_hi;
    logic [7:0]  r_spb;

    // Request state, as seen by the next block
    logic [63:0]      r_sector, n_sector;
    logic [IDX_W-1:0] r_bis, n_bis;
    logic             r_failed, n_failed;
    logic             r_zero_tw, n_zero_tw;
    logic [127:0]     r_tk_cur, n_tk_cur;

    logic w_adv;
    logic w_accept;

    // Fields of the incoming transfer
    logic [63:0] w_cipher_lo, w_cipher_hi, w_base, w_offset;
    logic        w_start, w_is_block;

    // Block attributes
    logic [127:0]     w_tkey;
    logic [63:0]      w_spb_ext;
    logic [63:0]      w_scaled;
    logic [63:0]      w_sum;
    logic [63:0]      w_start_sector;
    logic             w_start_fail;
    logic [63:0]      w_item_sector;
    logic [IDX_W-1:0] w_item_idx;
    logic             w_item_failed;
    logic             w_item_zero;

    logic               r_ent_v;
    axsd_pkg::t_enc_bus r_ent;
    axsd_pkg::t_enc_bus n_ent;

    logic               enc_v [11];
    axsd_pkg::t_enc_bus enc_d [11];
    logic               scl_v [IDX_W+1];
    axsd_pkg::t_scl_bus scl_d [IDX_W+1];
    logic               dec_v [11];
    axsd_pkg::t_dec_bus dec_d [11];

    assign w_cipher_lo = s_axis_tdata[63:0];
    assign w_cipher_hi = s_axis_tdata[127:64];
    assign w_base      = s_axis_tdata[191:128];
    assign w_offset    = s_axis_tdata[255:192];
    assign w_start     = s_axis_tuser[0];
    assign w_is_block  = s_axis_tuser[1];
    assign w_tkey      = {r_tkey_hi, r_tkey_lo};

    // The whole chain moves together; the last cell is the output register.
    assign w_adv         = !dec_v[10] || m_axis_tready;
    assign s_axis_tready = w_adv;
    assign w_accept      = s_axis_tvalid && w_adv;
    assign o_cfg_ready   = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dkey_lo <= '0;
            r_dkey_hi <= '0;
            r_tkey_lo <= '0;
            r_tkey_hi <= '0;
            r_spb     <= axsd_pkg::SPB_DEFAULT;
        end else if (i_cfg_valid) begin
            case (axsd_pkg::t_reg_idx'(i_cfg_index))
                axsd_pkg::REG_DKEY_LO: r_dkey_lo <= i_cfg_data;
                axsd_pkg::REG_DKEY_HI: r_dkey_hi <= i_cfg_data;
                axsd_pkg::REG_TKEY_LO: r_tkey_lo <= i_cfg_data;
                axsd_pkg::REG_TKEY_HI: r_tkey_hi <= i_cfg_data;
                axsd_pkg::REG_SPB:     r_spb     <= i_cfg_data[7:0];
                default: ;
            endcase
        end
    end

    // Starting sector of a request. A zero sectors_per_block counts as 8.
    // In sector mode the base is below 2^63 when used, so base + offset
    // cannot carry out; bit 63 of the sum then flags either upward overflow
    // (positive offset, saturate) or a negative sector (negative offset, fail).
    always_comb begin
        w_spb_ext    = {56'h0, (r_spb == 8'h00) ? axsd_pkg::SPB_DEFAULT : r_spb};
        w_scaled     = w_base * w_spb_ext;
        w_sum        = w_base + w_offset;
        w_start_fail = 1'b0;
        if (w_is_block) begin
            w_start_sector = w_scaled;
        end else if (w_base[63]) begin
            w_start_sector = axsd_pkg::SECTOR_MAX;
        end else if (!w_offset[63]) begin
            w_start_sector = w_sum[63] ? axsd_pkg::SECTOR_MAX : w_sum;
        end else if (w_sum[63]) begin
            w_start_sector = '0;
            w_start_fail   = 1'b1;
        end else begin
            w_start_sector = w_sum;
        end
    end

    // A tweak load (request start or sector advance) latches the tweak key;
    // the rest of that sector keeps using it.
    always_comb begin
        w_item_sector = w_start ? w_start_sector : r_sector;
        w_item_idx    = w_start ? '0 : r_bis;
        w_item_failed = w_start ? w_start_fail : r_failed;
        w_item_zero   = w_start ? 1'b0 : r_zero_tw;

        n_sector  = r_sector;
        n_bis     = r_bis;
        n_failed  = r_failed;
        n_zero_tw = r_zero_tw;
        n_tk_cur  = r_tk_cur;
        if (w_accept) begin
            n_failed = w_item_failed;
            if (w_start) begin
                n_tk_cur = w_tkey;
            end
            if (w_item_idx == IDX_LAST) begin
                // sector done: advance, and the next tweak comes from the key
                n_bis     = '0;
                n_sector  = w_item_sector + 64'd1;
                n_zero_tw = 1'b0;
                n_tk_cur  = w_tkey;
            end else begin
                n_bis     = w_item_idx + IDX_W'(1);
                n_sector  = w_item_sector;
                n_zero_tw = w_item_zero;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sector  <= '0;
            r_bis     <= '0;
            r_failed  <= 1'b0;
            r_zero_tw <= 1'b1;
            r_tk_cur  <= '0;
        end else begin
            r_sector  <= n_sector;
            r_bis     <= n_bis;
            r_failed  <= n_failed;
            r_zero_tw <= n_zero_tw;
            r_tk_cur  <= n_tk_cur;
        end
    end

    always_comb begin
        n_ent.st      = {64'h0, w_item_sector};
        n_ent.tk      = w_start ? w_tkey : r_tk_cur;
        n_ent.dk      = {r_dkey_hi, r_dkey_lo};
        n_ent.ct      = {w_cipher_hi, w_cipher_lo};
        n_ent.idx     = axsd_pkg::IDX_MAX_W'(w_item_idx);
        n_ent.failed  = w_item_failed;
        n_ent.zero_tw = w_item_zero;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ent_v <= 1'b0;
        end else if (w_adv) begin
            r_ent_v <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_ent <= n_ent;
        end
    end

    assign enc_v[0] = r_ent_v;
    assign enc_d[0] = r_ent;

    // Tweak encryption: ten round cells.
    for (genvar g = 1; g <= 10; g++) begin : g_enc
        axsd_enc_cell #(.ROUND(g)) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_adv   (w_adv),
            .i_valid (enc_v[g-1]),
            .i_data  (enc_d[g-1]),
            .o_valid (enc_v[g]),
            .o_data  (enc_d[g])
        );
    end

    assign scl_v[0]        = enc_v[10];
    assign scl_d[0].tw     = enc_d[10].st;
    assign scl_d[0].dk     = enc_d[10].dk;
    assign scl_d[0].ct     = enc_d[10].ct;
    assign scl_d[0].idx    = enc_d[10].idx;
    assign scl_d[0].failed = enc_d[10].failed;

    // Tweak scaling: one cell per block index bit.
    for (genvar g = 0; g < IDX_W; g++) begin : g_scl
        axsd_scale_cell #(.BIT(g)) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_adv   (w_adv),
            .i_valid (scl_v[g]),
            .i_data  (scl_d[g]),
            .o_valid (scl_v[g+1]),
            .o_data  (scl_d[g+1])
        );
    end

    // Apply the tweak and the last round key before the first decryption round.
    assign dec_v[0]        = scl_v[IDX_W];
    assign dec_d[0].st     = scl_d[IDX_W].ct ^ scl_d[IDX_W].tw ^ scl_d[IDX_W].dk;
    assign dec_d[0].tw     = scl_d[IDX_W].tw;
    assign dec_d[0].dk     = scl_d[IDX_W].dk;
    assign dec_d[0].failed = scl_d[IDX_W].failed;

    // Decryption: rounds nine down to zero.
    for (genvar g = 0; g < 10; g++) begin : g_dec
        axsd_dec_cell #(.ROUND(9 - g)) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_adv   (w_adv),
            .i_valid (dec_v[g]),
            .i_data  (dec_d[g]),
            .o_valid (dec_v[g+1]),
            .o_data  (dec_d[g+1])
        );
    end

    assign m_axis_tvalid = dec_v[10];
    assign m_axis_tdata  = dec_d[10].st;
    assign m_axis_tuser  = dec_d[10].failed;

endmodule

// ===== hw/rtl/axsd_checker.sv =====
// Port-level checks for the XTS sector decryptor, bound to the top level.
module axsd_checker (
    input logic         i_clk,
    input logic         i_rst_n,
    input logic         s_axis_tready,
    input logic         m_axis_tvalid,
    input logic         m_axis_tready,
    input logic [127:0] m_axis_tdata,
    input logic         m_axis_tuser
);

    // Reset empties the chain.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("output valid after reset");

    // A stalled result holds.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
            && $stable(m_axis_tuser))
        else $error("stalled result changed");

    // A failed request delivers zero plaintext.
    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser |-> m_axis_tdata == '0)
        else $error("error result with nonzero data");

    // An empty output register never blocks the input.
    a_ready_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !m_axis_tvalid |-> s_axis_tready)
        else $error("input stalled with empty output");

endmodule

bind aes_xts_sector_decrypt axsd_checker u_axsd_checker (.*);
